### src/assert_macros.svh
// Assertion helpers for the RTL, included by the top-level packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/msbp_pkg.sv
`timescale 1ns / 1ps

package msbp_pkg;

  localparam int unsigned MaxWidthDefault = 32;
  localparam int unsigned ValueBits       = 32;
  localparam int unsigned ByteBits        = 8;
  localparam int unsigned WidthBits       = 6;
  localparam logic [WidthBits-1:0] BitWidthReset = 6'd8;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic                 last_value;
  } in_t;

  typedef struct packed {
    logic [ByteBits-1:0] out_byte;
    logic                last_byte;
  } out_t;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic w_zero;
    logic slot_free;
    logic done;
  } status_t;

  // Mask of the n low bits of a byte, n from 0 to 8.
  function automatic logic [ByteBits-1:0] low_mask(input logic [3:0] n);
    logic [ByteBits-1:0] m;
    case (n)
      4'd0:    m = 8'h00;
      4'd1:    m = 8'h01;
      4'd2:    m = 8'h03;
      4'd3:    m = 8'h07;
      4'd4:    m = 8'h0F;
      4'd5:    m = 8'h1F;
      4'd6:    m = 8'h3F;
      4'd7:    m = 8'h7F;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

### src/msbp_ctrl.sv
`timescale 1ns / 1ps

module msbp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  msbp_pkg::status_t status_i,
  output msbp_pkg::cmd_t    cmd_o
);

  msbp_pkg::state_e state_q, state_d;

  assign in_ready_o  = (state_q == msbp_pkg::StIdle);
  assign cmd_o.load  = in_valid_i && in_ready_o && !status_i.w_zero;
  assign cmd_o.step  = (state_q == msbp_pkg::StRun) && status_i.slot_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      msbp_pkg::StIdle: begin
        if (cmd_o.load) state_d = msbp_pkg::StRun;
      end
      msbp_pkg::StRun: begin
        if (cmd_o.step && status_i.done) state_d = msbp_pkg::StIdle;
      end
      default: state_d = msbp_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msbp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/msbp_datapath.sv
`timescale 1ns / 1ps

module msbp_datapath #(
  parameter int unsigned MAX_WIDTH = msbp_pkg::MaxWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [msbp_pkg::WidthBits-1:0]     cfg_wdata_i,
  input  msbp_pkg::in_t                      in_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output msbp_pkg::out_t                     out_data_o,
  input  msbp_pkg::cmd_t                     cmd_i,
  output msbp_pkg::status_t                  status_o
);

  localparam int unsigned LimitInt = (MAX_WIDTH < msbp_pkg::ValueBits) ?
                                     MAX_WIDTH : msbp_pkg::ValueBits;
  localparam logic [msbp_pkg::WidthBits-1:0] Limit     = LimitInt[msbp_pkg::WidthBits-1:0];
  localparam logic [msbp_pkg::WidthBits-1:0] ValueW    = 6'd32;
  localparam logic [3:0]                     FreeEmpty = 4'd8;

  logic [msbp_pkg::WidthBits-1:0] bw_q;
  logic [msbp_pkg::WidthBits-1:0] w;
  logic [31:0]                    vq_q, vq_d;
  logic [msbp_pkg::WidthBits-1:0] rem_q, rem_d;
  logic                           last_q, last_d;
  logic [7:0]                     hold_q, hold_d;
  logic [3:0]                     free_q, free_d;
  logic                           out_valid_q, out_valid_d;
  msbp_pkg::out_t                 out_q, out_d;

  logic [7:0]                     top8;
  logic [msbp_pkg::WidthBits-1:0] free_w;
  logic                           rem_ge;
  logic [7:0]                     emit_byte;
  logic [2:0]                     rem3;
  logic [7:0]                     taken;
  logic [7:0]                     merged;
  logic [3:0]                     free_after;

  // Clamp the register to MAX_WIDTH or to what a value can carry, whichever is smaller.
  assign w = (bw_q > Limit) ? Limit : bw_q;

  assign top8       = vq_q[31:24];
  assign free_w     = {2'b00, free_q};
  assign rem_ge     = (rem_q >= free_w);
  assign emit_byte  = hold_q | (top8 >> (FreeEmpty - free_q));
  assign rem3       = rem_q[2:0];
  assign taken      = top8 & ~msbp_pkg::low_mask(FreeEmpty - {1'b0, rem3});
  assign merged     = hold_q | (taken >> (FreeEmpty - free_q));
  assign free_after = free_q - {1'b0, rem3};

  assign status_o.w_zero    = (w == '0);
  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign status_o.done      = (rem_q <= free_w);

  always_comb begin
    vq_d        = vq_q;
    rem_d       = rem_q;
    last_d      = last_q;
    hold_d      = hold_q;
    free_d      = free_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      // Left-align the used bits so the next bit always sits at bit 31.
      vq_d   = in_data_i.value << (ValueW - w);
      rem_d  = w;
      last_d = in_data_i.last_value;
    end else if (cmd_i.step) begin
      if (rem_ge) begin
        out_d.out_byte  = emit_byte;
        out_d.last_byte = last_q && (rem_q == free_w);
        out_valid_d     = 1'b1;
        vq_d            = vq_q << free_q;
        rem_d           = rem_q - free_w;
        hold_d          = '0;
        free_d          = FreeEmpty;
      end else if (last_q) begin
        if (free_after != FreeEmpty) begin
          out_d.out_byte  = merged;
          out_d.last_byte = 1'b1;
          out_valid_d     = 1'b1;
        end
        rem_d  = '0;
        hold_d = '0;
        free_d = FreeEmpty;
      end else begin
        rem_d  = '0;
        hold_d = merged;
        free_d = free_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q        <= msbp_pkg::BitWidthReset;
      hold_q      <= '0;
      free_q      <= FreeEmpty;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) bw_q <= cfg_wdata_i;
      hold_q      <= hold_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vq_q   <= vq_d;
    rem_q  <= rem_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/msb_first_bit_packer.sv
`timescale 1ns / 1ps

// MSB-first bit packer: each input transaction carries a 32-bit value whose low
// bit_width bits are appended, most significant bit first, to a continuous bit
// stream; every completed byte leaves as one output transaction with the first
// bit in bit 7. A transaction marked last_value flushes any partial byte,
// left-aligned and zero-padded, and the final byte of the list carries
// last_byte. A bit_width of zero makes the block ignore the item altogether
// (no bytes, no flush); such an item is accepted while the block stays idle.
// bit_width resets to 8 and saturates at MAX_WIDTH or 32, whichever is
// smaller; write it only while the block is idle. The block works on one item
// at a time. An item is loaded, then handled in datapath steps, one step per
// cycle while the output register can take a byte (a step waits while it is
// still full and out_ready_i is low); each step emits at most one byte into
// the output register. The number of steps is the number of bytes the item
// completes, plus one when bits remain for the partial byte or the flush.
module msb_first_bit_packer #(
  parameter int unsigned MAX_WIDTH = msbp_pkg::MaxWidthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msbp_pkg::WidthBits-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  msbp_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output msbp_pkg::out_t                 out_data_o
);

  `include "assert_macros.svh"

  msbp_pkg::cmd_t    cmd;
  msbp_pkg::status_t status;

  // Sequence the load and the per-byte steps.
  msbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold the width register, the partial byte and the output register.
  msbp_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // A load and a step never coincide: the controller is either idle or busy.
  `ASSERT_NEVER(a_load_step_excl, cmd.load && cmd.step, "load and step in one cycle")
  // A packed item blocks the input in the following cycle.
  `ASSERT_CLK(a_busy_after_load, cmd.load |=> !in_ready_o, "input open right after load")
  // A step only runs when the output register can take its byte.
  `ASSERT_CLK(a_step_slot, cmd.step |-> (!out_valid_o || out_ready_i), "step with full output")

endmodule
